/* rtl/knat_pkg.sv */
// Package for the keyed normal averaging table: sizes, status codes,
// controller states and the packed layouts of the two table memories.
// It depends on nothing else.
`timescale 1ns / 1ps

package knat_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int FILL_W  = $clog2(ENTRIES + 1);
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 32;
  localparam int KEY_W   = 32;
  localparam int NRM_W   = 16;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2,
    ST_SAT  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    KIND_ACC    = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DIVIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] z;
    logic [KEY_W-1:0] y;
    logic [KEY_W-1:0] x;
  } key_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum_z;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_x;
  } dat_t;

endpackage

/* rtl/keyed_normal_averaging_table_unit.sv */
// Top level of the keyed normal averaging table: key and data memories,
// scan controller and a three-lane restoring divider for the mean.
// Depends on knat_pkg.
`timescale 1ns / 1ps

// Usage
// The input stream carries one item per transfer: in_tuser is the kind
// (accumulate or look up), in_tdata the key words and the normal. Each item
// gives exactly one result transfer on the output stream: out_tuser is the
// status, out_tdata the mean normal and the sample count.
// The table is searched linearly: each occupied entry costs one memory read
// and one compare, up to the hit or the end of the table. A lookup hit on an
// entry with a nonzero count adds a run of the bit-serial divider, which
// works the three components side by side.
// The key memory read port sets the search rate.
// One item is in work at a time; the next is accepted as soon as the current
// result has been handed to the output register, even while that register
// still waits for the receiver. A stalled receiver holds the result and,
// once the next result is ready, the block waits.
// Reset empties the table at once through its fill count; no clearing pass
// is needed, as only entries below the fill count are ever read.

module keyed_normal_averaging_table_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // tdata: key_x, key_y, key_z, in_normal_x, in_normal_y, in_normal_z
  input  logic [143:0]  in_tdata,
  // tuser: kind
  input  logic [0:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // tdata: mean_x, mean_y, mean_z, sample_count
  output logic [63:0]   out_tdata,
  // tuser: status
  output logic [1:0]    out_tuser
);
  import knat_pkg::*;

  // Table memories
  key_t key_mem [ENTRIES];
  dat_t dat_mem [ENTRIES];
  key_t key_q;
  dat_t dat_q;

  state_t state_r, state_nxt;

  // Item held during the search
  kind_t                   kind_r;
  key_t                    key_r;
  logic signed [NRM_W-1:0] nrm_r [3];

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] scan_r;

  // Divider state, one lane per component
  logic [SUM_W-1:0] dvd_r [3];
  logic [CNT_W:0]   rem_r [3];
  logic             neg_r [3];
  logic [CNT_W-1:0] cnt_r;
  logic [STEP_W-1:0] step_r;

  // Result waiting for the output register
  status_t          res_status_r;
  logic [NRM_W-1:0] res_mean_r [3];

  logic [63:0] out_data_r;
  logic [1:0]  out_user_r;
  logic        out_valid_r;

  // Control decoded from the state
  logic            in_xfer;
  logic            at_end;
  logic            hit;
  logic            rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic            wr_en;
  logic [IDX_W-1:0] wr_addr;
  dat_t            wr_dat;
  logic            key_wr;
  logic            slot_free;
  dat_t            acc_dat;
  logic [SUM_W-1:0] sum_abs [3];
  logic [CNT_W:0]   rem_sh [3];
  logic             q_bit [3];
  logic [SUM_W-1:0] quo [3];

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign at_end    = (scan_r == fill_r);
  assign hit       = (key_q == key_r);
  assign slot_free = !out_valid_r || out_tready;

  // Sums and count of the hit entry, with the item's normal added and the count raised by one
  always_comb begin
    acc_dat       = dat_q;
    acc_dat.sum_x = dat_q.sum_x + SUM_W'(nrm_r[0]);
    acc_dat.sum_y = dat_q.sum_y + SUM_W'(nrm_r[1]);
    acc_dat.sum_z = dat_q.sum_z + SUM_W'(nrm_r[2]);
    acc_dat.count = dat_q.count + CNT_W'(1);
  end

  // Magnitudes of the sums for the divider
  always_comb begin
    sum_abs[0] = dat_q.sum_x[SUM_W-1] ? SUM_W'(-dat_q.sum_x) : SUM_W'(dat_q.sum_x);
    sum_abs[1] = dat_q.sum_y[SUM_W-1] ? SUM_W'(-dat_q.sum_y) : SUM_W'(dat_q.sum_y);
    sum_abs[2] = dat_q.sum_z[SUM_W-1] ? SUM_W'(-dat_q.sum_z) : SUM_W'(dat_q.sum_z);
  end

  // One restoring step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {rem_r[i][CNT_W-1:0], dvd_r[i][SUM_W-1]};
      q_bit[i]  = (rem_sh[i] >= {1'b0, cnt_r});
      quo[i]    = {dvd_r[i][SUM_W-2:0], q_bit[i]};
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_xfer) state_nxt = S_SCAN_RD;
      S_SCAN_RD:  state_nxt = at_end ? S_DONE : S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (!hit) state_nxt = S_SCAN_RD;
        else if (kind_r == KIND_LOOKUP && dat_q.count != '0) state_nxt = S_DIVIDE;
        else state_nxt = S_DONE;
      end
      S_DIVIDE:   if (step_r == STEP_W'(SUM_W - 1)) state_nxt = S_DONE;
      S_DONE:     if (slot_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Memory control
  always_comb begin
    rd_en   = (state_r == S_SCAN_RD) && !at_end;
    rd_addr = scan_r[IDX_W-1:0];
    wr_en   = 1'b0;
    key_wr  = 1'b0;
    wr_addr = scan_r[IDX_W-1:0];
    wr_dat  = acc_dat;
    case (state_r)
      S_SCAN_CMP: begin
        wr_en = hit && kind_r == KIND_ACC && dat_q.count != COUNT_MAX;
      end
      S_SCAN_RD: begin
        if (at_end && kind_r == KIND_ACC && fill_r != FILL_W'(ENTRIES)) begin
          wr_en  = 1'b1;
          key_wr = 1'b1;
          wr_addr = fill_r[IDX_W-1:0];
          wr_dat.sum_x = SUM_W'(nrm_r[0]);
          wr_dat.sum_y = SUM_W'(nrm_r[1]);
          wr_dat.sum_z = SUM_W'(nrm_r[2]);
          wr_dat.count = CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) dat_mem[wr_addr] <= wr_dat;
    if (key_wr) key_mem[wr_addr] <= key_r;
    if (rd_en) begin
      key_q <= key_mem[rd_addr];
      dat_q <= dat_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Fill count and scan pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      scan_r <= '0;
    end else begin
      if (key_wr) fill_r <= fill_r + FILL_W'(1);
      if (in_xfer) scan_r <= '0;
      else if (state_r == S_SCAN_CMP && !hit) scan_r <= scan_r + FILL_W'(1);
    end
  end

  // Item capture, result forming and the divider
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r   <= kind_t'(in_tuser[0]);
      key_r.x  <= in_tdata[31:0];
      key_r.y  <= in_tdata[63:32];
      key_r.z  <= in_tdata[95:64];
      nrm_r[0] <= in_tdata[111:96];
      nrm_r[1] <= in_tdata[127:112];
      nrm_r[2] <= in_tdata[143:128];
    end
    case (state_r)
      S_SCAN_RD: begin
        if (at_end) begin
          res_mean_r[0] <= '0;
          res_mean_r[1] <= '0;
          res_mean_r[2] <= '0;
          if (kind_r == KIND_LOOKUP) begin
            res_status_r <= ST_MISS;
            cnt_r        <= '0;
          end else if (fill_r == FILL_W'(ENTRIES)) begin
            res_status_r <= ST_FULL;
            cnt_r        <= '0;
          end else begin
            res_status_r <= ST_OK;
            cnt_r        <= CNT_W'(1);
          end
        end
      end
      S_SCAN_CMP: begin
        if (hit) begin
          res_mean_r[0] <= '0;
          res_mean_r[1] <= '0;
          res_mean_r[2] <= '0;
          step_r        <= '0;
          neg_r[0]      <= dat_q.sum_x[SUM_W-1];
          neg_r[1]      <= dat_q.sum_y[SUM_W-1];
          neg_r[2]      <= dat_q.sum_z[SUM_W-1];
          for (int i = 0; i < 3; i++) begin
            dvd_r[i] <= sum_abs[i];
            rem_r[i] <= '0;
          end
          if (kind_r == KIND_LOOKUP) begin
            res_status_r <= ST_OK;
            cnt_r        <= dat_q.count;
          end else if (dat_q.count == COUNT_MAX) begin
            res_status_r <= ST_SAT;
            cnt_r        <= COUNT_MAX;
          end else begin
            res_status_r <= ST_OK;
            cnt_r        <= acc_dat.count;
          end
        end
      end
      S_DIVIDE: begin
        step_r <= step_r + STEP_W'(1);
        for (int i = 0; i < 3; i++) begin
          dvd_r[i] <= quo[i];
          rem_r[i] <= q_bit[i] ? (rem_sh[i] - {1'b0, cnt_r}) : rem_sh[i];
          if (step_r == STEP_W'(SUM_W - 1)) begin
            res_mean_r[i] <= neg_r[i] ? NRM_W'(-quo[i]) : quo[i][NRM_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && slot_free) begin
      out_data_r <= {cnt_r, res_mean_r[2], res_mean_r[1], res_mean_r[0]};
      out_user_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(ENTRIES))
    else $error("fill count beyond table size");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("second item taken while one is in work");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVIDE) |-> (cnt_r != '0))
    else $error("divider started with a zero count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_CMP) |-> (scan_r < fill_r))
    else $error("search compared an unoccupied entry");

endmodule
